// ===== design/ppcieu_pkg.sv =====
package ppcieu_pkg;

    localparam int XLEN = 32;

    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_ADDC    = 6'd1;
    localparam logic [5:0] OP_ADDE    = 6'd2;
    localparam logic [5:0] OP_ADDI    = 6'd3;
    localparam logic [5:0] OP_ADDIC   = 6'd4;
    localparam logic [5:0] OP_ADDIC_R = 6'd5;
    localparam logic [5:0] OP_ADDIS   = 6'd6;
    localparam logic [5:0] OP_ADDME   = 6'd7;
    localparam logic [5:0] OP_ADDZE   = 6'd8;
    localparam logic [5:0] OP_AND     = 6'd9;
    localparam logic [5:0] OP_ANDC    = 6'd10;
    localparam logic [5:0] OP_ANDI_R  = 6'd11;
    localparam logic [5:0] OP_ANDIS_R = 6'd12;
    localparam logic [5:0] OP_CNTLZW  = 6'd13;
    localparam logic [5:0] OP_DIVW    = 6'd14;
    localparam logic [5:0] OP_DIVWU   = 6'd15;
    localparam logic [5:0] OP_EQV     = 6'd16;
    localparam logic [5:0] OP_EXTSB   = 6'd17;
    localparam logic [5:0] OP_EXTSH   = 6'd18;
    localparam logic [5:0] OP_MULHW   = 6'd19;
    localparam logic [5:0] OP_MULHWU  = 6'd20;
    localparam logic [5:0] OP_MULLI   = 6'd21;
    localparam logic [5:0] OP_MULLW   = 6'd22;
    localparam logic [5:0] OP_NAND    = 6'd23;
    localparam logic [5:0] OP_NEG     = 6'd24;
    localparam logic [5:0] OP_NOR     = 6'd25;
    localparam logic [5:0] OP_OR      = 6'd26;
    localparam logic [5:0] OP_ORC     = 6'd27;
    localparam logic [5:0] OP_ORI     = 6'd28;
    localparam logic [5:0] OP_ORIS    = 6'd29;
    localparam logic [5:0] OP_RLWIMI  = 6'd30;
    localparam logic [5:0] OP_RLWINM  = 6'd31;
    localparam logic [5:0] OP_RLWNM   = 6'd32;
    localparam logic [5:0] OP_SLW     = 6'd33;
    localparam logic [5:0] OP_SRW     = 6'd34;
    localparam logic [5:0] OP_SRAW    = 6'd35;
    localparam logic [5:0] OP_SRAWI   = 6'd36;
    localparam logic [5:0] OP_SUBF    = 6'd37;
    localparam logic [5:0] OP_SUBFC   = 6'd38;
    localparam logic [5:0] OP_SUBFE   = 6'd39;
    localparam logic [5:0] OP_SUBFIC  = 6'd40;
    localparam logic [5:0] OP_SUBFME  = 6'd41;
    localparam logic [5:0] OP_SUBFZE  = 6'd42;
    localparam logic [5:0] OP_XOR     = 6'd43;
    localparam logic [5:0] OP_XORI    = 6'd44;
    localparam logic [5:0] OP_XORIS   = 6'd45;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_ALU,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [15:0] imm;
        logic [4:0]  sh;
        logic [4:0]  mb;
        logic [4:0]  me;
        kind_t       kind;
        logic [4:0]  dst;
        logic        ca_upd;
        logic        ov_upd;
        logic        cr_upd;
    } dec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_AB,
        ST_READ_S,
        ST_EXEC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIX,
        ST_DIV_LOOP,
        ST_DIV_FIX,
        ST_COMMIT
    } bstate_t;

endpackage

// ===== design/ppcieu_front.sv =====
module ppcieu_front
    import ppcieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  opcode,
    input  logic [4:0]  first_reg,
    input  logic [4:0]  second_reg,
    input  logic [4:0]  third_reg,
    input  logic [15:0] immediate,
    input  logic [4:0]  shift_amount,
    input  logic [4:0]  mask_begin,
    input  logic [4:0]  mask_end,
    input  logic        overflow_enable,
    input  logic        record_enable,
    output logic        q_valid,
    output dec_t        q_data,
    input  logic        q_pop
);

    dec_t       entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, rptr_reg;
    dec_t       dec;
    logic       ov_allow, rec_allow, rec_always;
    logic       do_push, do_pop;

    always_comb
    begin
        dec          = '0;
        dec.op       = opcode;
        dec.rd       = first_reg;
        dec.ra       = second_reg;
        dec.rb       = third_reg;
        dec.imm      = immediate;
        dec.sh       = shift_amount;
        dec.mb       = mask_begin;
        dec.me       = mask_end;
        dec.kind     = KIND_ALU;
        dec.dst      = second_reg;
        ov_allow     = 1'b0;
        rec_allow    = 1'b1;
        rec_always   = 1'b0;
        unique case (opcode) inside
            OP_ADD, OP_ADDC, OP_ADDE, OP_ADDME, OP_ADDZE, OP_SUBF, OP_SUBFC,
            OP_SUBFE, OP_SUBFME, OP_SUBFZE, OP_NEG:
            begin
                dec.dst  = first_reg;
                ov_allow = 1'b1;
            end
            OP_ADDI, OP_ADDIC, OP_ADDIS, OP_SUBFIC:
            begin
                dec.dst   = first_reg;
                rec_allow = 1'b0;
            end
            OP_ADDIC_R:
            begin
                dec.dst    = first_reg;
                rec_always = 1'b1;
            end
            OP_ANDI_R, OP_ANDIS_R: rec_always = 1'b1;
            OP_ORI, OP_ORIS, OP_XORI, OP_XORIS: rec_allow = 1'b0;
            OP_DIVW, OP_DIVWU:
            begin
                dec.dst  = first_reg;
                dec.kind = KIND_DIV;
                ov_allow = 1'b1;
            end
            OP_MULHW, OP_MULHWU:
            begin
                dec.dst  = first_reg;
                dec.kind = KIND_MUL;
            end
            OP_MULLW:
            begin
                dec.dst  = first_reg;
                dec.kind = KIND_MUL;
                ov_allow = 1'b1;
            end
            OP_MULLI:
            begin
                dec.dst   = first_reg;
                dec.kind  = KIND_MUL;
                rec_allow = 1'b0;
            end
            OP_AND, OP_ANDC, OP_CNTLZW, OP_EQV, OP_EXTSB, OP_EXTSH, OP_NAND,
            OP_NOR, OP_OR, OP_ORC, OP_RLWIMI, OP_RLWINM, OP_RLWNM, OP_SLW,
            OP_SRW, OP_SRAW, OP_SRAWI, OP_XOR: ;
            default:
            begin
                dec.kind  = KIND_NONE;
                dec.dst   = '0;
                rec_allow = 1'b0;
            end
        endcase
        case (opcode) inside
            OP_ADDC, OP_ADDE, OP_ADDIC, OP_ADDIC_R, OP_ADDME, OP_ADDZE, OP_SUBFC,
            OP_SUBFE, OP_SUBFIC, OP_SUBFME, OP_SUBFZE, OP_SRAW, OP_SRAWI:
                dec.ca_upd = 1'b1;
            default: dec.ca_upd = 1'b0;
        endcase
        dec.ov_upd = ov_allow & overflow_enable;
        dec.cr_upd = rec_always | (rec_allow & record_enable);
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = q_pop & q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push & ~do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop & ~do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wptr_reg <= ~wptr_reg;
            if (do_pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= dec;
    end

endmodule

// ===== design/ppcieu_back.sv =====
module ppcieu_back
    import ppcieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  dec_t        q_data,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  written_reg,
    output logic [31:0] written_value,
    output logic [3:0]  cr0_flags,
    output logic        carry_flag,
    output logic        overflow_flag,
    output logic        summary_overflow_flag
);

    logic [XLEN-1:0] rf_mem [32];
    logic [31:0]     rf_vld_reg;
    logic [XLEN-1:0] rd_a_reg, rd_b_reg, rd_s_reg;

    bstate_t state_reg, state_next;
    dec_t    cur_reg;

    logic       carry_reg, ov_reg, so_reg;
    logic [3:0] cr_reg;

    logic [XLEN-1:0] res_reg, res_next;
    logic            ca_res_reg, ca_res_next;
    logic            ov_res_reg, ov_res_next;

    logic [63:0]     prod_reg;
    logic [XLEN-1:0] quo_reg, dvs_reg, rem_reg;
    logic [4:0]      cnt_reg;
    logic            neg_reg;

    logic            out_valid_reg;
    logic [4:0]      out_reg_reg;
    logic [XLEN-1:0] out_val_reg;
    logic [3:0]      out_cr_reg;
    logic            out_ca_reg, out_ov_reg, out_so_reg;

    logic [XLEN-1:0] a_val, b_val, s_val, a0_val, simm;
    logic [XLEN-1:0] add_a, add_b;
    logic            add_cin;
    logic [XLEN:0]   add_wide;
    logic [XLEN-1:0] rot, mask, mul_b, sra_res;
    logic [63:0]     rot2;
    logic [4:0]      rot_n, sra_n;
    logic            sra_big, sra_ca;
    logic [5:0]      clz;
    logic            div_sgn, div_ovf;
    logic [XLEN:0]   rem_sh;
    logic [XLEN-1:0] mul_hi;
    logic [15:0]     mul_half;
    logic [47:0]     part_prod;
    logic            out_free, commit;
    logic            ca_n, ov_n, so_n;
    logic [3:0]      cr_n;

    assign a_val  = rf_vld_reg[cur_reg.ra] ? rd_a_reg : '0;
    assign b_val  = rf_vld_reg[cur_reg.rb] ? rd_b_reg : '0;
    assign s_val  = rf_vld_reg[cur_reg.rd] ? rd_s_reg : '0;
    assign a0_val = (cur_reg.ra == 5'd0) ? '0 : a_val;
    assign simm   = {{16{cur_reg.imm[15]}}, cur_reg.imm};
    assign mul_b  = (cur_reg.op == OP_MULLI) ? simm : b_val;

    // one shared 32x16 multiplier, low half of the operand first
    assign mul_half  = (state_reg == ST_MUL_LO) ? mul_b[15:0] : mul_b[31:16];
    assign part_prod = {16'h0, a_val} * {32'h0, mul_half};

    assign out_free = ~out_valid_reg | pop;
    assign commit   = (state_reg == ST_COMMIT) & out_free;
    assign q_pop    = q_valid & ((state_reg == ST_IDLE) | commit);

    always_comb
    begin
        add_a   = a_val;
        add_b   = b_val;
        add_cin = 1'b0;
        case (cur_reg.op) inside
            OP_ADDE: add_cin = carry_reg;
            OP_ADDI: begin add_a = a0_val; add_b = simm; end
            OP_ADDIC, OP_ADDIC_R: add_b = simm;
            OP_ADDIS: begin add_a = a0_val; add_b = {cur_reg.imm, 16'h0}; end
            OP_ADDME: begin add_b = '1; add_cin = carry_reg; end
            OP_ADDZE: begin add_b = '0; add_cin = carry_reg; end
            OP_SUBF, OP_SUBFC: begin add_a = ~a_val; add_cin = 1'b1; end
            OP_SUBFE: begin add_a = ~a_val; add_cin = carry_reg; end
            OP_SUBFIC: begin add_a = ~a_val; add_b = simm; add_cin = 1'b1; end
            OP_SUBFME: begin add_a = ~a_val; add_b = '1; add_cin = carry_reg; end
            OP_SUBFZE: begin add_a = ~a_val; add_b = '0; add_cin = carry_reg; end
            default: ;
        endcase
        add_wide = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, add_cin};
    end

    // rotate and PowerPC mask (bit 0 is the msb)
    always_comb
    begin
        logic [XLEN-1:0] hi, lo;
        rot_n = (cur_reg.op == OP_RLWNM) ? b_val[4:0] : cur_reg.sh;
        rot2  = {s_val, s_val} << rot_n;
        rot   = rot2[63:32];
        hi    = '1 >> cur_reg.mb;
        lo    = '1 << (5'd31 - cur_reg.me);
        mask  = (cur_reg.mb <= cur_reg.me) ? (hi & lo) : (hi | lo);
    end

    always_comb
    begin
        sra_big = (cur_reg.op == OP_SRAW) & b_val[5];
        sra_n   = (cur_reg.op == OP_SRAW) ? b_val[4:0] : cur_reg.sh;
        if (sra_big)
        begin
            sra_res = {XLEN{s_val[31]}};
            sra_ca  = s_val[31];
        end
        else
        begin
            sra_res = $unsigned($signed(s_val) >>> sra_n);
            sra_ca  = s_val[31] & ((s_val & ~('1 << sra_n)) != '0);
        end
    end

    always_comb
    begin
        clz = 6'd32;
        for (int i = 0; i < XLEN; i++)
            if (s_val[i])
                clz = 6'(31 - i);
    end

    assign div_sgn = (cur_reg.op == OP_DIVW);
    assign div_ovf = (b_val == '0) |
                     (div_sgn & (a_val == 32'h8000_0000) & (b_val == 32'hFFFF_FFFF));
    assign rem_sh  = {rem_reg, quo_reg[31]};
    assign mul_hi  = prod_reg[63:32]
                     - ((cur_reg.op != OP_MULHWU && a_val[31]) ? mul_b : '0)
                     - ((cur_reg.op != OP_MULHWU && mul_b[31]) ? a_val : '0);

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        ca_res_next = ca_res_reg;
        ov_res_next = ov_res_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = ST_READ_AB;
            ST_READ_AB: state_next = ST_READ_S;
            ST_READ_S:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                state_next  = ST_COMMIT;
                ca_res_next = add_wide[XLEN];
                ov_res_next = ((add_a ^ add_wide[31:0]) & (add_b ^ add_wide[31:0])) >> 31 != 0;
                res_next    = add_wide[31:0];
                case (cur_reg.op) inside
                    OP_AND:     res_next = s_val & b_val;
                    OP_ANDC:    res_next = s_val & ~b_val;
                    OP_ANDI_R:  res_next = s_val & {16'h0, cur_reg.imm};
                    OP_ANDIS_R: res_next = s_val & {cur_reg.imm, 16'h0};
                    OP_CNTLZW:  res_next = {26'h0, clz};
                    OP_EQV:     res_next = ~(s_val ^ b_val);
                    OP_EXTSB:   res_next = {{24{s_val[7]}}, s_val[7:0]};
                    OP_EXTSH:   res_next = {{16{s_val[15]}}, s_val[15:0]};
                    OP_NAND:    res_next = ~(s_val & b_val);
                    OP_NOR:     res_next = ~(s_val | b_val);
                    OP_OR:      res_next = s_val | b_val;
                    OP_ORC:     res_next = s_val | ~b_val;
                    OP_ORI:     res_next = s_val | {16'h0, cur_reg.imm};
                    OP_ORIS:    res_next = s_val | {cur_reg.imm, 16'h0};
                    OP_XOR:     res_next = s_val ^ b_val;
                    OP_XORI:    res_next = s_val ^ {16'h0, cur_reg.imm};
                    OP_XORIS:   res_next = s_val ^ {cur_reg.imm, 16'h0};
                    OP_RLWIMI:  res_next = (rot & mask) | (a_val & ~mask);
                    OP_RLWINM, OP_RLWNM: res_next = rot & mask;
                    OP_SLW:     res_next = b_val[5] ? '0 : s_val << b_val[4:0];
                    OP_SRW:     res_next = b_val[5] ? '0 : s_val >> b_val[4:0];
                    OP_SRAW, OP_SRAWI:
                    begin
                        res_next    = sra_res;
                        ca_res_next = sra_ca;
                    end
                    OP_NEG:
                    begin
                        res_next    = ~a_val + 32'd1;
                        ov_res_next = (a_val == 32'h8000_0000);
                    end
                    OP_DIVW, OP_DIVWU:
                    begin
                        ov_res_next = div_ovf;
                        res_next    = (div_sgn & a_val[31]) ? '1 : '0;
                        if (!div_ovf)
                            state_next = ST_DIV_LOOP;
                    end
                    OP_MULHW, OP_MULHWU, OP_MULLI, OP_MULLW:
                        state_next = ST_MUL_LO;
                    default:
                        if (cur_reg.kind == KIND_NONE)
                            res_next = '0;
                endcase
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_MUL_FIX;
            ST_MUL_FIX:
            begin
                state_next  = ST_COMMIT;
                res_next    = (cur_reg.op == OP_MULHW || cur_reg.op == OP_MULHWU) ?
                              mul_hi : prod_reg[31:0];
                ov_res_next = (mul_hi != {XLEN{prod_reg[31]}});
            end
            ST_DIV_LOOP:
                if (cnt_reg == 5'd31)
                    state_next = ST_DIV_FIX;
            ST_DIV_FIX:
            begin
                state_next = ST_COMMIT;
                res_next   = neg_reg ? (~quo_reg + 32'd1) : quo_reg;
            end
            ST_COMMIT:
                if (out_free)
                    state_next = q_valid ? ST_READ_AB : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ca_n = cur_reg.ca_upd ? ca_res_reg : carry_reg;
        ov_n = cur_reg.ov_upd ? ov_res_reg : ov_reg;
        so_n = so_reg | (cur_reg.ov_upd & ov_res_reg);
        if (!cur_reg.cr_upd)
            cr_n = cr_reg;
        else if (res_reg == '0)
            cr_n = {3'b001, so_n};
        else if (res_reg[31])
            cr_n = {3'b100, so_n};
        else
            cr_n = {3'b010, so_n};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rf_vld_reg    <= '0;
            carry_reg     <= 1'b0;
            ov_reg        <= 1'b0;
            so_reg        <= 1'b0;
            cr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                if (cur_reg.kind != KIND_NONE)
                    rf_vld_reg[cur_reg.dst] <= 1'b1;
                carry_reg     <= ca_n;
                ov_reg        <= ov_n;
                so_reg        <= so_n;
                cr_reg        <= cr_n;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (state_reg == ST_READ_AB)
        begin
            rd_a_reg <= rf_mem[cur_reg.ra];
            rd_b_reg <= rf_mem[cur_reg.rb];
        end
        if (state_reg == ST_READ_S)
            rd_s_reg <= rf_mem[cur_reg.rd];
        if (commit && cur_reg.kind != KIND_NONE)
            rf_mem[cur_reg.dst] <= res_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        ca_res_reg <= ca_res_next;
        ov_res_reg <= ov_res_next;
        if (state_reg == ST_MUL_LO)
            prod_reg <= {16'h0, part_prod};
        if (state_reg == ST_MUL_HI)
            prod_reg <= prod_reg + {part_prod, 16'h0};
        if (state_reg == ST_EXEC)
        begin
            quo_reg <= (div_sgn & a_val[31]) ? (~a_val + 32'd1) : a_val;
            dvs_reg <= (div_sgn & b_val[31]) ? (~b_val + 32'd1) : b_val;
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= div_sgn & (a_val[31] ^ b_val[31]);
        end
        // one quotient bit per cycle, restoring
        if (state_reg == ST_DIV_LOOP)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= 32'(rem_sh - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (commit)
        begin
            out_reg_reg <= cur_reg.dst;
            out_val_reg <= res_reg;
            out_cr_reg  <= cr_n;
            out_ca_reg  <= ca_n;
            out_ov_reg  <= ov_n;
            out_so_reg  <= so_n;
        end
    end

    assign empty                 = ~out_valid_reg;
    assign written_reg           = out_reg_reg;
    assign written_value         = out_val_reg;
    assign cr0_flags             = out_cr_reg;
    assign carry_flag            = out_ca_reg;
    assign overflow_flag         = out_ov_reg;
    assign summary_overflow_flag = out_so_reg;

endmodule

// ===== design/powerpc_integer_execute_unit.sv =====
// 32-bit PowerPC integer execute unit. Words pushed in are decoded into a
// two-entry queue; the back end then reads the register file (states
// READ_AB then READ_S, two read ports), executes and commits into a one-word
// result register. Multiplies take two 32x16 partial products plus a sign
// fixup; divides produce one quotient bit per cycle. Register file, XER and
// CR0 reset to zero.
module powerpc_integer_execute_unit
    import ppcieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [5:0]  opcode,
    input  logic [4:0]  first_reg,
    input  logic [4:0]  second_reg,
    input  logic [4:0]  third_reg,
    input  logic [15:0] immediate,
    input  logic [4:0]  shift_amount,
    input  logic [4:0]  mask_begin,
    input  logic [4:0]  mask_end,
    input  logic        overflow_enable,
    input  logic        record_enable,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  written_reg,
    output logic [31:0] written_value,
    output logic [3:0]  cr0_flags,
    output logic        carry_flag,
    output logic        overflow_flag,
    output logic        summary_overflow_flag
);

    logic q_valid, q_pop;
    dec_t q_data;

    ppcieu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .first_reg       (first_reg),
        .second_reg      (second_reg),
        .third_reg       (third_reg),
        .immediate       (immediate),
        .shift_amount    (shift_amount),
        .mask_begin      (mask_begin),
        .mask_end        (mask_end),
        .overflow_enable (overflow_enable),
        .record_enable   (record_enable),
        .q_valid         (q_valid),
        .q_data          (q_data),
        .q_pop           (q_pop)
    );

    ppcieu_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .q_valid               (q_valid),
        .q_data                (q_data),
        .q_pop                 (q_pop),
        .empty                 (empty),
        .pop                   (pop),
        .written_reg           (written_reg),
        .written_value         (written_value),
        .cr0_flags             (cr0_flags),
        .carry_flag            (carry_flag),
        .overflow_flag         (overflow_flag),
        .summary_overflow_flag (summary_overflow_flag)
    );

endmodule

// ===== dv/ieu_checker.sv =====
module ieu_checker
    import ppcieu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [5:0]  opcode,
    input  logic [4:0]  first_reg,
    input  logic [4:0]  second_reg,
    input  logic [4:0]  third_reg,
    input  logic [15:0] immediate,
    input  logic [4:0]  shift_amount,
    input  logic [4:0]  mask_begin,
    input  logic [4:0]  mask_end,
    input  logic        overflow_enable,
    input  logic        record_enable,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  written_reg,
    input  logic [31:0] written_value,
    input  logic [3:0]  cr0_flags,
    input  logic        carry_flag,
    input  logic        overflow_flag,
    input  logic        summary_overflow_flag,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [4:0]  wreg;
        logic [31:0] wval;
        logic [3:0]  cr;
        logic        ca;
        logic        ov;
        logic        so;
    } retire_t;

    logic [31:0] gpr [32];
    logic        xer_ca, xer_ov, xer_so;
    logic [3:0]  cr0;
    retire_t     retire_q [$];

    assign pending = retire_q.size();

    initial fail_count = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void set_cr(input logic [31:0] v);
        cr0 = {v[31], !v[31] && v != 0, v == 0, xer_so};
    endfunction

    function automatic void set_ov(input logic f);
        xer_ov = f;
        if (f) xer_so = 1'b1;
    endfunction

    // kind: 0 no record, 1 oe/rc controlled, 2 always record
    function automatic logic [31:0] add3(input logic [31:0] a, input logic [31:0] b,
                                         input logic c, input logic setca, input int kind,
                                         input logic oe, input logic rc);
        logic [32:0] w;
        w = {1'b0, a} + {1'b0, b} + c;
        if (setca) xer_ca = w[32];
        if (kind == 2) set_cr(w[31:0]);
        else if (kind == 1) begin
            if (oe) set_ov(((a ^ w[31:0]) & (b ^ w[31:0])) >> 31 != 0);
            if (rc) set_cr(w[31:0]);
        end
        return w[31:0];
    endfunction

    function automatic logic [31:0] rot_mask(input logic [4:0] mb, input logic [4:0] me);
        logic [31:0] hi, lo;
        hi = 32'hFFFF_FFFF >> mb;
        lo = 32'hFFFF_FFFF << (31 - me);
        return (mb <= me) ? (hi & lo) : (hi | lo);
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] s, input logic [4:0] n);
        logic [63:0] t;
        t = {s, s} >> (32 - n);
        return t[31:0];
    endfunction

    function automatic logic [31:0] shift_arith(input logic [31:0] s, input logic [5:0] n);
        logic [31:0] r;
        logic c;
        c = 1'b0;
        if (n[5]) begin
            r = {32{s[31]}};
            c = s[31];
        end else begin
            r = $signed(s) >>> n[4:0];
            if (s[31] && n[4:0] != 0 && (s & ((32'd1 << n[4:0]) - 1)) != 0) c = 1'b1;
        end
        xer_ca = c;
        return r;
    endfunction

    function automatic retire_t execute(input logic [5:0] op, input logic [4:0] rd,
                                        input logic [4:0] ra, input logic [4:0] rb,
                                        input logic [15:0] imm, input logic [4:0] sh,
                                        input logic [4:0] mb, input logic [4:0] me,
                                        input logic oe, input logic rc);
        logic [31:0] a, b, s, a0, simm, v, m;
        logic [4:0] dst;
        logic ok, bad, rec;
        logic signed [63:0] sp;
        logic [63:0] up;
        retire_t r;
        a = gpr[ra]; b = gpr[rb]; s = gpr[rd];
        a0 = (ra == 0) ? 32'd0 : a;
        simm = {{16{imm[15]}}, imm};
        v = 0; dst = ra; ok = 1'b1; rec = rc;
        case (op)
            OP_ADD:     begin dst = rd; v = add3(a, b, 0, 0, 1, oe, rc); rec = 0; end
            OP_ADDC:    begin dst = rd; v = add3(a, b, 0, 1, 1, oe, rc); rec = 0; end
            OP_ADDE:    begin dst = rd; v = add3(a, b, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_ADDI:    begin dst = rd; v = add3(a0, simm, 0, 0, 0, oe, rc); rec = 0; end
            OP_ADDIC:   begin dst = rd; v = add3(a, simm, 0, 1, 0, oe, rc); rec = 0; end
            OP_ADDIC_R: begin dst = rd; v = add3(a, simm, 0, 1, 2, oe, rc); rec = 0; end
            OP_ADDIS:   begin dst = rd; v = add3(a0, simm << 16, 0, 0, 0, oe, rc); rec = 0; end
            OP_ADDME:   begin dst = rd; v = add3(a, '1, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_ADDZE:   begin dst = rd; v = add3(a, 0, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_AND:     v = s & b;
            OP_ANDC:    v = s & ~b;
            OP_ANDI_R:  begin v = s & {16'd0, imm}; rec = 1; end
            OP_ANDIS_R: begin v = s & {imm, 16'd0}; rec = 1; end
            OP_CNTLZW:  begin
                v = 32;
                for (int i = 0; i < 32; i++)
                    if (s[i]) v = 31 - i;
            end
            OP_DIVW, OP_DIVWU: begin
                dst = rd;
                bad = (b == 0) || (op == OP_DIVW && a == 32'h8000_0000 && b == '1);
                if (bad) v = (op == OP_DIVW && a[31]) ? '1 : 0;
                else if (op == OP_DIVW) v = $signed(a) / $signed(b);
                else v = a / b;
                if (oe) set_ov(bad);
            end
            OP_EQV:     v = ~(s ^ b);
            OP_EXTSB:   v = {{24{s[7]}}, s[7:0]};
            OP_EXTSH:   v = {{16{s[15]}}, s[15:0]};
            OP_MULHW, OP_MULLI, OP_MULLW: begin
                dst = rd;
                sp = $signed({{32{a[31]}}, a}) *
                     $signed(op == OP_MULLI ? {{32{simm[31]}}, simm} : {{32{b[31]}}, b});
                v = (op == OP_MULHW) ? sp[63:32] : sp[31:0];
                if (op == OP_MULLW && oe) set_ov(sp != $signed({{32{sp[31]}}, sp[31:0]}));
                if (op == OP_MULLI) rec = 0;
            end
            OP_MULHWU: begin dst = rd; up = {32'd0, a} * {32'd0, b}; v = up[63:32]; end
            OP_NAND:    v = ~(s & b);
            OP_NEG:     begin dst = rd; v = ~a + 1; if (oe) set_ov(a == 32'h8000_0000); end
            OP_NOR:     v = ~(s | b);
            OP_OR:      v = s | b;
            OP_ORC:     v = s | ~b;
            OP_ORI:     begin v = s | {16'd0, imm}; rec = 0; end
            OP_ORIS:    begin v = s | {imm, 16'd0}; rec = 0; end
            OP_RLWIMI:  begin m = rot_mask(mb, me); v = (rotl(s, sh) & m) | (a & ~m); end
            OP_RLWINM:  v = rotl(s, sh) & rot_mask(mb, me);
            OP_RLWNM:   v = rotl(s, b[4:0]) & rot_mask(mb, me);
            OP_SLW:     v = b[5] ? 0 : s << b[4:0];
            OP_SRW:     v = b[5] ? 0 : s >> b[4:0];
            OP_SRAW:    v = shift_arith(s, b[5:0]);
            OP_SRAWI:   v = shift_arith(s, {1'b0, sh});
            OP_SUBF:    begin dst = rd; v = add3(~a, b, 1, 0, 1, oe, rc); rec = 0; end
            OP_SUBFC:   begin dst = rd; v = add3(~a, b, 1, 1, 1, oe, rc); rec = 0; end
            OP_SUBFE:   begin dst = rd; v = add3(~a, b, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_SUBFIC:  begin dst = rd; v = add3(~a, simm, 1, 1, 0, oe, rc); rec = 0; end
            OP_SUBFME:  begin dst = rd; v = add3(~a, '1, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_SUBFZE:  begin dst = rd; v = add3(~a, 0, xer_ca, 1, 1, oe, rc); rec = 0; end
            OP_XOR:     v = s ^ b;
            OP_XORI:    begin v = s ^ {16'd0, imm}; rec = 0; end
            OP_XORIS:   begin v = s ^ {imm, 16'd0}; rec = 0; end
            default:    begin ok = 0; dst = 0; v = 0; rec = 0; end
        endcase
        if (rec) set_cr(v);
        if (ok) gpr[dst] = v;
        r.wreg = dst; r.wval = v; r.cr = cr0;
        r.ca = xer_ca; r.ov = xer_ov; r.so = xer_so;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        retire_t want;
        if (!rst_n) begin
            for (int i = 0; i < 32; i++) gpr[i] = 0;
            xer_ca = 0; xer_ov = 0; xer_so = 0; cr0 = 0;
            retire_q.delete();
        end else begin
            if (push && !full)
                retire_q.push_back(execute(opcode, first_reg, second_reg, third_reg,
                    immediate, shift_amount, mask_begin, mask_end,
                    overflow_enable, record_enable));
            if (pop && !empty) begin
                if (retire_q.size() == 0) begin
                    report("unexpected word", written_value, 0);
                end else begin
                    want = retire_q.pop_front();
                    if (written_reg !== want.wreg) report("written_reg", written_reg, want.wreg);
                    if (written_value !== want.wval)
                        report("written_value", written_value, want.wval);
                    if (cr0_flags !== want.cr) report("cr0_flags", cr0_flags, want.cr);
                    if (carry_flag !== want.ca) report("carry_flag", carry_flag, want.ca);
                    if (overflow_flag !== want.ov)
                        report("overflow_flag", overflow_flag, want.ov);
                    if (summary_overflow_flag !== want.so)
                        report("summary_overflow_flag", summary_overflow_flag, want.so);
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import ppcieu_pkg::*;

    logic        clk, rst_n, push, full, empty, pop;
    logic [5:0]  opcode;
    logic [4:0]  first_reg, second_reg, third_reg, shift_amount, mask_begin, mask_end;
    logic [15:0] immediate;
    logic        overflow_enable, record_enable;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic [3:0]  cr0_flags;
    logic        carry_flag, overflow_flag, summary_overflow_flag;
    int          fail_count, pending, cycles;

    powerpc_integer_execute_unit dut (.*);
    ieu_checker chk (.*);

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // consumer: pop with random stalls, mostly short and now and then long
    initial
    begin
        int n;
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n = gap_len();
            if (n == 0)
                pop <= 1'b1;
            else
            begin
                pop <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    task automatic send(input logic [5:0] op, input logic [4:0] rd, input logic [4:0] ra,
                        input logic [4:0] rb, input logic [15:0] imm, input logic [4:0] sh,
                        input logic [4:0] mb, input logic [4:0] me,
                        input logic oe, input logic rc);
        push <= 1; opcode <= op; first_reg <= rd; second_reg <= ra; third_reg <= rb;
        immediate <= imm; shift_amount <= sh; mask_begin <= mb; mask_end <= me;
        overflow_enable <= oe; record_enable <= rc;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            push <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // values in registers 1..31 (addis then addi) so that operands hit extremes
    task automatic load_reg(input logic [4:0] r, input logic [31:0] v);
        send(OP_ADDIS, r, 0, 0, v[31:16] + v[15], 0, 0, 0, 0, 0);
        send(OP_ADDI, r, r, 0, v[15:0], 0, 0, 0, 0, 0);
    endtask

    task automatic random_item();
        logic [5:0] op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) op = $urandom_range(46, 63);
        else op = $urandom_range(0, 45);
        if (r >= 3 && r < 15) load_reg($urandom_range(0, 31),
            ($urandom_range(0, 3) == 0) ? {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'd0}
                                         - $urandom_range(0, 1) : $urandom());
        send(op, $urandom_range(0, 31), $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 31),
             $urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 31),
             $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1),
             $urandom_range(0, 1));
    endtask

    initial begin
        push = 0; opcode = 0; first_reg = 0; second_reg = 0; third_reg = 0;
        immediate = 0; shift_amount = 0; mask_begin = 0; mask_end = 0;
        overflow_enable = 0; record_enable = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: operand extremes and the special cases
        load_reg(1, 32'h8000_0000);
        load_reg(2, 32'hFFFF_FFFF);
        load_reg(3, 32'h7FFF_FFFF);
        send(OP_ADDI, 4, 0, 0, 16'hFFFF, 0, 0, 0, 0, 1);     // rA=0 reads zero
        send(OP_ADDIS, 5, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
        send(OP_DIVW, 6, 1, 2, 0, 0, 0, 0, 1, 1);             // signed divide overflow
        send(OP_DIVW, 7, 1, 0, 0, 0, 0, 0, 1, 1);             // divide by zero, negative
        send(OP_DIVWU, 8, 3, 0, 0, 0, 0, 0, 1, 0);
        send(OP_ADD, 9, 3, 3, 0, 0, 0, 0, 1, 1);              // overflow, record sees SO
        send(OP_SRAW, 10, 1, 3, 0, 0, 0, 0, 0, 1);            // shift >= 32, sign fill
        send(OP_SLW, 2, 11, 3, 0, 0, 0, 0, 0, 1);
        send(OP_SRAWI, 1, 12, 0, 0, 31, 0, 0, 0, 1);
        send(OP_RLWINM, 2, 13, 0, 0, 31, 31, 0, 0, 1);        // wrapped mask
        send(OP_RLWIMI, 3, 14, 0, 0, 0, 0, 31, 0, 0);
        send(OP_MULLW, 15, 1, 2, 0, 0, 0, 0, 1, 1);
        send(OP_MULHW, 16, 1, 1, 0, 0, 0, 0, 0, 1);
        send(OP_NEG, 17, 1, 0, 0, 0, 0, 0, 1, 1);
        send(OP_CNTLZW, 0, 18, 0, 0, 0, 0, 0, 0, 1);
        send(6'd63, 31, 31, 31, 16'hFFFF, 31, 31, 31, 1, 1);
        for (int op = 0; op < 46; op++)
            send(op, op % 32, (op + 1) % 32, (op + 2) % 32, 16'h8001, 5, 3, 20, 1, 1);

        for (int n = 0; n < 1500; n++) begin
            random_item();
            idle(gap_len());
            if (n == 700) begin
                push <= 0;
                while (pending != 0) @(posedge clk);
            end
        end
        push <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ppcieu_pkg.sv
design/ppcieu_front.sv
design/ppcieu_back.sv
design/powerpc_integer_execute_unit.sv
dv/ieu_checker.sv
dv/tb_top.sv
